[design/iirdf2_pkg.sv]
// Shared widths, constants and types of the direct form II IIR filter.
`default_nettype none

package iirdf2_pkg;

  localparam int DEF_ORDER = 2;

  localparam int S_W    = 16;              // Q1.15 sample
  localparam int C_W    = 16;              // Q2.14 coefficient
  localparam int W_W    = 24;              // Q9.15 delay element
  localparam int PROD_W = C_W + W_W;       // full product
  localparam int FRAC   = 14;              // product shift back to Q.15
  localparam int RND_W  = PROD_W - FRAC;   // rounded product
  localparam int ACC_W  = RND_W + 2;       // room for x plus up to three products

  localparam int PDATA_W = 32;
  localparam int PADDR_W = 5;
  localparam int REG_W   = 3;

  // Register indexes
  localparam logic [REG_W-1:0] REG_B0 = 3'd0;
  localparam logic [REG_W-1:0] REG_B1 = 3'd1;
  localparam logic [REG_W-1:0] REG_B2 = 3'd2;
  localparam logic [REG_W-1:0] REG_A1 = 3'd3;
  localparam logic [REG_W-1:0] REG_A2 = 3'd4;

  localparam logic signed [C_W-1:0] B0_RESET = 16'sd16384;

  localparam logic signed [ACC_W-1:0] W_HI = ACC_W'((2 ** (W_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] W_LO = ACC_W'(-(2 ** (W_W - 1)));
  localparam logic signed [ACC_W-1:0] Y_HI = ACC_W'((2 ** (S_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] Y_LO = ACC_W'(-(2 ** (S_W - 1)));

  // Accumulator operations of the shared multiply-accumulate unit
  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_e;

endpackage

`default_nettype wire

[design/iirdf2_mac.sv]
// Shared multiply, round-to-nearest and accumulate unit.
`default_nettype none

module iirdf2_mac (
  input  wire                                      clk_i,
  input  iirdf2_pkg::mac_op_e                      op_i,
  input  wire logic signed [iirdf2_pkg::ACC_W-1:0] load_i,
  input  wire logic signed [iirdf2_pkg::C_W-1:0]   coef_i,
  input  wire logic signed [iirdf2_pkg::W_W-1:0]   opnd_i,
  output logic signed      [iirdf2_pkg::ACC_W-1:0] acc_o
);
  import iirdf2_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [RND_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  rnd_ext;
  logic signed [ACC_W-1:0]  acc_d, acc_q;

  // floor((p + 2^13) / 2^14): ties go toward plus infinity
  assign prod     = coef_i * opnd_i;
  assign prod_rnd = prod + PROD_W'(2 ** (FRAC - 1));
  assign rnd      = prod_rnd[PROD_W-1:FRAC];
  assign rnd_ext  = ACC_W'(rnd);

  always_comb begin
    case (op_i)
      MAC_LOAD: acc_d = load_i;
      MAC_ADD:  acc_d = acc_q + rnd_ext;
      MAC_SUB:  acc_d = acc_q - rnd_ext;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

[design/iir_direct_form_two_filter.sv]
// Top level: direct form II IIR filter with one shared multiply-accumulate.
//
//  channel   direction  handshake              payload
//  ------    ---------  ---------------------  -------------------------
//  input     in         in_valid_i/in_stall_o  sample_in_i
//  output    out        out_valid_o/out_stall_i sample_out_o, saturated_o
//  config    in (APB)   psel/penable/pready    paddr, pwdata, prdata
//
// For each sample the block goes through these steps before it is ready again:
// the transfer loads x into the accumulator, then one multiply-accumulate per
// feedback tap and per feedforward tap (b0 included), a step to clip w0 and
// one to clip y and shift the delay line. The single multiplier is why the
// taps are taken one after another.
// Reset clears the coefficients to b0 = 1.0, others zero, and the delay line.
// The result sits in an output register; the next sample is taken while it
// waits, and that sample's result holds in the last step until it drains.
`default_nettype none

module iir_direct_form_two_filter #(
  parameter int ORDER = iirdf2_pkg::DEF_ORDER
) (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  // sample input
  input  wire                                         in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [iirdf2_pkg::S_W-1:0]      sample_in_i,
  // sample output
  output logic                                        out_valid_o,
  input  wire                                         out_stall_i,
  output logic signed      [iirdf2_pkg::S_W-1:0]      sample_out_o,
  output logic                                        saturated_o,
  // configuration
  input  wire                                         psel,
  input  wire                                         penable,
  input  wire                                         pwrite,
  input  wire logic        [iirdf2_pkg::PADDR_W-1:0]  paddr,
  input  wire logic        [iirdf2_pkg::PDATA_W-1:0]  pwdata,
  output logic             [iirdf2_pkg::PDATA_W-1:0]  prdata,
  output logic                                        pready
);
  import iirdf2_pkg::*;

  localparam int STEP_W = $clog2(ORDER + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FB,
    S_CLIPW,
    S_FF,
    S_DONE
  } state_e;

  // ---------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------
  logic signed [C_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [REG_W-1:0]      reg_idx;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= B0_RESET;
      b1_q <= '0;
      b2_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_B0:  b0_q <= pwdata[C_W-1:0];
        REG_B1:  b1_q <= pwdata[C_W-1:0];
        REG_B2:  b2_q <= pwdata[C_W-1:0];
        REG_A1:  a1_q <= pwdata[C_W-1:0];
        REG_A2:  a2_q <= pwdata[C_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_B0:  prdata = PDATA_W'(b0_q);
      REG_B1:  prdata = PDATA_W'(b1_q);
      REG_B2:  prdata = PDATA_W'(b2_q);
      REG_A1:  prdata = PDATA_W'(a1_q);
      REG_A2:  prdata = PDATA_W'(a2_q);
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Sequencer and data path around the shared MAC
  // ---------------------------------------------------------------
  state_e                state_q;
  logic [STEP_W-1:0]     step_q;
  logic signed [W_W-1:0] delay_q [ORDER];
  logic signed [W_W-1:0] w0_q;
  logic                  sat_q;
  logic                  out_valid_q;
  logic signed [S_W-1:0] out_sample_q;
  logic                  out_sat_q;

  mac_op_e                mac_op;
  logic signed [ACC_W-1:0] mac_load;
  logic signed [C_W-1:0]   mac_coef;
  logic signed [W_W-1:0]   mac_opnd;
  logic signed [ACC_W-1:0] acc;

  logic [STEP_W-1:0]     dsel;
  logic signed [W_W-1:0] dval;
  logic                  last_fb, last_ff;
  logic signed [W_W-1:0] w_clip;
  logic                  w_ovf;
  logic signed [S_W-1:0] y_clip;
  logic                  y_ovf;
  logic                  out_free;

  assign last_fb  = (step_q == STEP_W'(ORDER - 1));
  assign last_ff  = (step_q == STEP_W'(ORDER));
  assign out_free = !out_valid_q || !out_stall_i;

  // Delay tap for this step: d[s] in the feedback pass, d[s-1] feedforward
  assign dsel = (state_q == S_FB) ? step_q : step_q - STEP_W'(1);

  always_comb begin
    dval = '0;
    for (int j = 0; j < ORDER; j++) begin
      if (dsel == STEP_W'(j)) dval = delay_q[j];
    end
  end

  // Taps beyond the register set (third order) have zero coefficients
  always_comb begin
    mac_coef = '0;
    if (state_q == S_FB) begin
      if (step_q == STEP_W'(0))                 mac_coef = a1_q;
      else if (ORDER > 1 && step_q == STEP_W'(1)) mac_coef = a2_q;
    end else begin
      if (step_q == STEP_W'(0))                 mac_coef = b0_q;
      else if (step_q == STEP_W'(1))            mac_coef = b1_q;
      else if (ORDER > 1 && step_q == STEP_W'(2)) mac_coef = b2_q;
    end
  end

  always_comb begin
    mac_op   = MAC_HOLD;
    mac_load = ACC_W'(sample_in_i);
    mac_opnd = dval;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) mac_op = MAC_LOAD;
      end
      S_FB: begin
        mac_op = MAC_SUB;
      end
      S_CLIPW: begin
        mac_op   = MAC_LOAD;
        mac_load = '0;
      end
      S_FF: begin
        mac_op = MAC_ADD;
        if (step_q == STEP_W'(0)) mac_opnd = w0_q;
      end
      default: ;
    endcase
  end

  iirdf2_mac u_mac (
    .clk_i  (clk_i),
    .op_i   (mac_op),
    .load_i (mac_load),
    .coef_i (mac_coef),
    .opnd_i (mac_opnd),
    .acc_o  (acc)
  );

  // Saturation of w0 and y
  always_comb begin
    w_ovf  = (acc > W_HI) || (acc < W_LO);
    w_clip = (acc > W_HI) ? W_HI[W_W-1:0] :
             (acc < W_LO) ? W_LO[W_W-1:0] : acc[W_W-1:0];
    y_ovf  = (acc > Y_HI) || (acc < Y_LO);
    y_clip = (acc > Y_HI) ? Y_HI[S_W-1:0] :
             (acc < Y_LO) ? Y_LO[S_W-1:0] : acc[S_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      w0_q         <= '0;
      sat_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_sat_q    <= 1'b0;
      for (int j = 0; j < ORDER; j++) delay_q[j] <= '0;
    end else begin
      // a new result may replace one that drains in the same cycle
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            step_q  <= '0;
            state_q <= S_FB;
          end
        end
        S_FB: begin
          if (last_fb) begin
            state_q <= S_CLIPW;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        S_CLIPW: begin
          w0_q    <= w_clip;
          sat_q   <= w_ovf;
          step_q  <= '0;
          state_q <= S_FF;
        end
        S_FF: begin
          if (last_ff) begin
            state_q <= S_DONE;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_sample_q <= y_clip;
            out_sat_q    <= sat_q || y_ovf;
            delay_q[0]   <= w0_q;
            for (int j = 1; j < ORDER; j++) delay_q[j] <= delay_q[j-1];
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign saturated_o  = out_sat_q;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Testbench top: directed table and random coefficient phases checked against a filter predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iirdf2_pkg::*;

  // Filter order of the instance; the predictor follows it (taps 1..FILT_ORDER).
  localparam int FILT_ORDER  = DEF_ORDER;
  localparam int RAND_ITEMS  = 1650;
  localparam int IDLE_LIMIT  = 2000;   // cycles without any transfer before giving up

  // Highest register index the address bus can reach; those past REG_A2 are holes.
  localparam logic [REG_W-1:0] REG_LAST = REG_W'((1 << REG_W) - 1);

  localparam logic signed [S_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [S_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [C_W-1:0] C_MAX = 16'sh7FFF;
  localparam logic signed [C_W-1:0] C_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [S_W-1:0] y;
    logic                  sat;
  } filt_out_t;

  typedef enum logic { ROW_CFG, ROW_SAMPLE } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [REG_W-1:0]      idx;
    logic signed [C_W-1:0] coef;
    logic signed [S_W-1:0] x;
    bit                    known;   // want holds a typed-in result
    filt_out_t             want;
  } stim_row_t;

  // How a random phase picks its coefficients.
  typedef enum int { CS_TOP, CS_BOTTOM, CS_EXTREME, CS_GENTLE, CS_WILD } coef_style_e;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic signed [S_W-1:0] sample_in_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [S_W-1:0] sample_out_o;
  logic                  saturated_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [PADDR_W-1:0]    paddr       = '0;
  logic [PDATA_W-1:0]    pwdata      = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  iir_direct_form_two_filter #(
    .ORDER(FILT_ORDER)
  ) u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sample_in_i,
    .out_valid_o,
    .out_stall_i,
    .sample_out_o,
    .saturated_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow of the coefficient registers and the delay line.
  // Index 3 of each coefficient array is never written, so a third tap reads 0.
  // ---------------------------------------------------------------------------
  logic signed [C_W-1:0] coef_ff [0:3];
  logic signed [C_W-1:0] coef_fb [0:3];
  logic signed [W_W-1:0] w_line  [0:2];

  filt_out_t pending_out [$];   // expected results, oldest first
  stim_row_t dir_rows    [$];   // directed table
  int        n_errors = 0;
  int        n_out    = 0;
  bit        burst_phase = 1'b0; // no input gaps during this phase

  // Q.29 product back to Q.15, to nearest, ties toward plus infinity.
  function automatic longint round_q15(longint p);
    return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  // One filter step: w0 from the feedback taps, y from the feedforward taps,
  // then w0 enters the delay line. Both sums clip at the end only.
  function automatic filt_out_t filter_step(logic signed [S_W-1:0] x);
    filt_out_t r;
    longint    acc;
    longint    w0;
    longint    y;
    bit        clipped;
    int        i;
    clipped = 1'b0;
    acc = longint'(x);
    for (i = 1; i <= FILT_ORDER; i++)
      acc -= round_q15(longint'(coef_fb[i]) * longint'(w_line[i-1]));
    w0 = acc;
    if (acc > longint'(W_HI)) begin
      w0 = longint'(W_HI);
      clipped = 1'b1;
    end else if (acc < longint'(W_LO)) begin
      w0 = longint'(W_LO);
      clipped = 1'b1;
    end
    y = round_q15(longint'(coef_ff[0]) * w0);
    for (i = 1; i <= FILT_ORDER; i++)
      y += round_q15(longint'(coef_ff[i]) * longint'(w_line[i-1]));
    if (y > longint'(Y_HI)) begin
      y = longint'(Y_HI);
      clipped = 1'b1;
    end else if (y < longint'(Y_LO)) begin
      y = longint'(Y_LO);
      clipped = 1'b1;
    end
    for (i = FILT_ORDER - 1; i > 0; i--)
      w_line[i] = w_line[i-1];
    w_line[0] = W_W'(w0);
    r.y   = S_W'(y);
    r.sat = clipped;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    $display("[%0t] result %0d: %s got %0d want %0d", $time, n_out, what, got, want);
  endtask

  // Gap or stall length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic signed [S_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0:       return S_MAX;
        1:       return S_MIN;
        2:       return '0;
        default: return -16'sd1;
      endcase
    end
    if (r < 25) return S_W'(int'($urandom_range(0, 512)) - 256);
    return S_W'($urandom);
  endfunction

  function automatic logic signed [C_W-1:0] pick_coef(coef_style_e style,
                                                      logic [REG_W-1:0] idx);
    case (style)
      CS_TOP:    return C_MAX;
      CS_BOTTOM: return C_MIN;
      CS_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          default: return B0_RESET;
        endcase
      end
      CS_GENTLE: begin
        // |a1|,|a2| < 0.5 keeps the poles inside the unit circle
        if (idx == REG_A1 || idx == REG_A2)
          return C_W'(int'($urandom_range(0, 16000)) - 8000);
        return C_W'(int'($urandom_range(0, 40000)) - 20000);
      end
      default:   return C_W'($urandom);
    endcase
  endfunction

  // APB write: setup cycle, access cycle, then psel and penable return low.
  task automatic write_coef(input logic [REG_W-1:0] idx, input logic signed [C_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= {{(PDATA_W - C_W){val[C_W-1]}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_B0:  coef_ff[0] = val;
      REG_B1:  coef_ff[1] = val;
      REG_B2:  coef_ff[2] = val;
      REG_A1:  coef_fb[1] = val;
      REG_A2:  coef_fb[2] = val;
      default: ;   // hole in the map: ignored
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one sample and hold it until the transfer; valid stays high after the
  // transfer so a back-to-back sample needs only one assignment per step.
  task automatic send_sample(input logic signed [S_W-1:0] x, input bit known,
                             input filt_out_t want);
    int        gap;
    filt_out_t pred;
    gap = burst_phase ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    pred = filter_step(x);   // always run: keeps the delay line in step
    pending_out.insert(pending_out.size(), known ? want : pred);
  endtask

  // Quiesce: input idle, every expected result drained, then an idle wait.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (2 * FILT_ORDER + 4) @(posedge clk_i);
  endtask

  task automatic add_cfg(input logic [REG_W-1:0] idx, input logic signed [C_W-1:0] val);
    stim_row_t row;
    row = '{kind: ROW_CFG, idx: idx, coef: val, x: '0, known: 1'b0, want: '0};
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_sample(input logic signed [S_W-1:0] x, input bit known = 1'b0,
                            input logic signed [S_W-1:0] y = '0, input logic sat = 1'b0);
    stim_row_t row;
    row = '{kind: ROW_SAMPLE, idx: REG_B0, coef: '0, x: x, known: known,
            want: '{y: y, sat: sat}};
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall runs, compare each transfer with the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  bit stall_on = 1'b0;
  int run_left = 0;

  always @(posedge clk_i) begin
    filt_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_out++;
        if (pending_out.size() == 0) begin
          report_mismatch("unexpected result, sample_out", int'(sample_out_o), 0);
        end else begin
          want = pending_out.pop_front();
          if (sample_out_o !== want.y)
            report_mismatch("sample_out", int'(sample_out_o), int'(want.y));
          if (saturated_o !== want.sat)
            report_mismatch("saturated", int'(saturated_o), int'(want.sat));
        end
      end
      // alternate free runs and stall runs; a zero-length stall means another free run
      if (run_left == 0) begin
        run_left = stall_on ? 0 : idle_len();
        stall_on = (run_left != 0);
        if (!stall_on) run_left = $urandom_range(1, 30);
      end
      run_left--;
      out_stall_i <= stall_on;
    end
  end

  // Watchdog: too long without a transfer on either channel ends the run.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          i;
    int          r;
    int          n_sent;
    int          len;
    int          phase;
    coef_style_e style;

    for (i = 0; i < 4; i++) begin
      coef_ff[i] = '0;
      coef_fb[i] = '0;
    end
    for (i = 0; i < 3; i++) w_line[i] = '0;
    coef_ff[0] = B0_RESET;

    // After reset b0 = 1.0 and all else zero: y passes x through.
    add_sample(16'sd0,    1'b1, 16'sd0,    1'b0);
    add_sample(S_MAX,     1'b1, S_MAX,     1'b0);
    add_sample(S_MIN,     1'b1, S_MIN,     1'b0);
    add_sample(16'sd1,    1'b1, 16'sd1,    1'b0);
    add_sample(-16'sd1,   1'b1, -16'sd1,   1'b0);
    add_sample(16'sh5555, 1'b1, 16'sh5555, 1'b0);
    add_sample(16'shAAAA, 1'b1, 16'shAAAA, 1'b0);
    // b0 near +2.0: full-scale input clips the output
    add_cfg(REG_B0, C_MAX);
    add_sample(S_MAX,     1'b1, S_MAX,     1'b1);
    add_sample(S_MIN,     1'b1, S_MIN,     1'b1);
    add_sample(16'sd0,    1'b1, 16'sd0,    1'b0);
    // b0 = -2.0: -2 * 0.5 lands exactly on full scale, -2 * -0.5 clips
    add_cfg(REG_B0, C_MIN);
    add_sample(16'sd16384,  1'b1, S_MIN, 1'b0);
    add_sample(-16'sd16384, 1'b1, S_MAX, 1'b1);
    // a1 = -2.0 doubles w each step: the delay element runs into its limit.
    // A write to a hole in the map must change nothing.
    add_cfg(REG_B0, B0_RESET);
    add_cfg(REG_A1, C_MIN);
    add_cfg(REG_LAST, C_MAX);
    for (i = 0; i < 9; i++) add_sample(S_MAX);
    add_sample(S_MIN);
    add_sample(S_MIN);
    // extreme taps on the delayed terms
    add_cfg(REG_A1, '0);
    add_cfg(REG_B1, C_MAX);
    add_cfg(REG_B2, C_MIN);
    add_cfg(REG_A2, C_MAX);
    add_sample(16'sd100);
    add_sample(-16'sd100);
    add_sample(16'sd0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        settle();
        write_coef(dir_rows[k].idx, dir_rows[k].coef);
      end else begin
        send_sample(dir_rows[k].x, dir_rows[k].known, dir_rows[k].want);
      end
    end

    // Random phases: new coefficients each phase, all-max and all-min first.
    n_sent = 0;
    phase  = 0;
    while (n_sent < RAND_ITEMS) begin
      settle();
      if (phase == 0)      style = CS_TOP;
      else if (phase == 1) style = CS_BOTTOM;
      else                 style = coef_style_e'($urandom_range(int'(CS_EXTREME), int'(CS_WILD)));
      for (r = int'(REG_B0); r <= int'(REG_A2); r++)
        write_coef(REG_W'(r), pick_coef(style, REG_W'(r)));
      if ($urandom_range(0, 2) == 0)
        write_coef(REG_W'($urandom_range(int'(REG_A2) + 1, int'(REG_LAST))), C_W'($urandom));
      burst_phase = ($urandom_range(0, 3) == 0);
      len = $urandom_range(40, 200);
      for (i = 0; i < len; i++) begin
        send_sample(pick_sample(), 1'b0, '0);
        n_sent++;
      end
      phase++;
    end
    burst_phase = 1'b0;

    settle();
    if (n_errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
